// ===== hdl/jfs_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jfs_pkg
// Shared types and byte codes for the JPEG frame size sniffer.
// ----------------------------------------------------------------------------
package jfs_pkg;

  localparam logic [7:0] BYTE_FF    = 8'hff;
  localparam logic [7:0] MARK_SOI   = 8'hd8;
  localparam logic [7:0] MARK_EOI   = 8'hd9;
  localparam logic [7:0] MARK_RST0  = 8'hd0;
  localparam logic [7:0] MARK_RST7  = 8'hd7;
  localparam logic [7:0] SOF_A_LO   = 8'hc0;
  localparam logic [7:0] SOF_A_HI   = 8'hc3;
  localparam logic [7:0] SOF_B_LO   = 8'hc5;
  localparam logic [7:0] SOF_B_HI   = 8'hc7;
  localparam logic [7:0] SOF_C_LO   = 8'hc9;
  localparam logic [7:0] SOF_C_HI   = 8'hcb;
  localparam logic [7:0] SOF_D_LO   = 8'hcd;
  localparam logic [7:0] SOF_D_HI   = 8'hcf;

  localparam logic [15:0] MIN_SEG_LEN = 16'd2;
  localparam logic [15:0] MIN_SOF_LEN = 16'd7;

  // offsets inside the SOF body
  localparam logic [2:0] SOF_OFF_H_HI = 3'd1;
  localparam logic [2:0] SOF_OFF_H_LO = 3'd2;
  localparam logic [2:0] SOF_OFF_W_HI = 3'd3;
  localparam logic [2:0] SOF_OFF_W_LO = 3'd4;
  localparam logic [2:0] SOF_OFF_MAX  = 3'd5;

  typedef enum logic [3:0] {
    PH_START0 = 4'd0,
    PH_START1 = 4'd1,
    PH_SEEK   = 4'd2,
    PH_MARKER = 4'd3,
    PH_LENHI  = 4'd4,
    PH_LENLO  = 4'd5,
    PH_SKIP   = 4'd6,
    PH_SOF    = 4'd7
  } phase_t;

  typedef struct packed {
    phase_t      phase;
    logic [15:0] remaining;
    logic [7:0]  marker;
    logic [7:0]  len_hi;
    logic [2:0]  sof_off;
    logic [15:0] height;
    logic [15:0] width;
    logic        decided;
  } jfs_state_t;

  typedef struct packed {
    logic        vld;
    logic        size_found;
    logic [15:0] image_width;
    logic [15:0] image_height;
  } jfs_result_t;

endpackage

// ===== hdl/jfs_ifs.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jfs_ifs
// Byte request channel and size result channel of the frame size sniffer.
// ----------------------------------------------------------------------------
interface jfs_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] stream_byte;
  logic       frame_end;

  modport source (output valid, output stream_byte, output frame_end, input ready);
  modport sink   (input valid, input stream_byte, input frame_end, output ready);
endinterface

interface jfs_out_if;
  logic        valid;
  logic        ready;
  logic        size_found;
  logic [15:0] image_width;
  logic [15:0] image_height;

  modport source (output valid, output size_found, output image_width,
                  output image_height, input ready);
  modport sink   (input valid, input size_found, input image_width,
                  input image_height, output ready);
endinterface

// ===== hdl/jfs_parser.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jfs_parser
// Per-byte marker parser: next parse state and optional result for one byte.
// ----------------------------------------------------------------------------
module jfs_parser (
  input  jfs_pkg::jfs_state_t  state_i,
  input  logic [7:0]           byte_i,
  input  logic                 last_i,
  output jfs_pkg::jfs_state_t  state_o,
  output jfs_pkg::jfs_result_t result_o
);
  import jfs_pkg::*;

  function automatic logic marker_alone(input logic [7:0] m);
    return (m == MARK_SOI) || (m == MARK_EOI) || (m >= MARK_RST0 && m <= MARK_RST7);
  endfunction

  function automatic logic marker_sof(input logic [7:0] m);
    return (m >= SOF_A_LO && m <= SOF_A_HI) || (m >= SOF_B_LO && m <= SOF_B_HI) ||
           (m >= SOF_C_LO && m <= SOF_C_HI) || (m >= SOF_D_LO && m <= SOF_D_HI);
  endfunction

  logic [15:0] seg_len;
  logic [15:0] rem_dec;
  logic [15:0] height_new;
  logic [15:0] width_new;
  logic        is_sof;
  logic        zero_fail;
  logic        fail;
  logic        ok;
  phase_t      phase_nxt;

  assign seg_len = {state_i.len_hi, byte_i};
  assign rem_dec = (state_i.remaining != 16'd0) ? state_i.remaining - 16'd1
                                                : state_i.remaining;
  assign is_sof  = marker_sof(state_i.marker);

  always_comb begin
    height_new = state_i.height;
    width_new  = state_i.width;
    case (state_i.sof_off)
      SOF_OFF_H_HI: height_new = {byte_i, state_i.height[7:0]};
      SOF_OFF_H_LO: height_new = {state_i.height[15:8], byte_i};
      SOF_OFF_W_HI: width_new  = {byte_i, state_i.width[7:0]};
      SOF_OFF_W_LO: width_new  = {state_i.width[15:8], byte_i};
      default: ;
    endcase
  end

  // size check lands on the width low byte
  assign zero_fail = (state_i.sof_off == SOF_OFF_W_LO) &&
                     ((height_new == 16'd0) || (width_new == 16'd0));

  // decision for this byte
  always_comb begin
    fail = 1'b0;
    ok   = 1'b0;
    if (!state_i.decided) begin
      case (state_i.phase)
        PH_START0: fail = (byte_i != BYTE_FF);
        PH_START1: fail = (byte_i != MARK_SOI);
        PH_LENLO:  fail = (seg_len < MIN_SEG_LEN) || (is_sof && (seg_len < MIN_SOF_LEN));
        PH_SOF: begin
          if (zero_fail) fail = 1'b1;
          else           ok   = (rem_dec == 16'd0);
        end
        PH_SEEK, PH_MARKER, PH_LENHI, PH_SKIP: ;
        default: fail = 1'b1;
      endcase
    end
  end

  // next phase
  always_comb begin
    phase_nxt = state_i.phase;
    if (last_i) begin
      phase_nxt = PH_START0;
    end else if (!state_i.decided) begin
      case (state_i.phase)
        PH_START0: if (byte_i == BYTE_FF) phase_nxt = PH_START1;
        PH_START1: if (byte_i == MARK_SOI) phase_nxt = PH_SEEK;
        PH_SEEK:   if (byte_i == BYTE_FF) phase_nxt = PH_MARKER;
        PH_MARKER: phase_nxt = marker_alone(byte_i) ? PH_SEEK : PH_LENHI;
        PH_LENHI:  phase_nxt = PH_LENLO;
        PH_LENLO: begin
          if (!fail) begin
            if (is_sof)                        phase_nxt = PH_SOF;
            else if (seg_len == MIN_SEG_LEN)   phase_nxt = PH_SEEK;
            else                               phase_nxt = PH_SKIP;
          end
        end
        PH_SKIP:   if (rem_dec == 16'd0) phase_nxt = PH_SEEK;
        default: ;
      endcase
    end
  end

  // data fields and result
  always_comb begin
    state_o       = state_i;
    state_o.phase = phase_nxt;
    if (last_i) begin
      state_o = '0;
    end else if (!state_i.decided) begin
      case (state_i.phase)
        PH_MARKER: state_o.marker = byte_i;
        PH_LENHI:  state_o.len_hi = byte_i;
        PH_LENLO: begin
          if (!fail) begin
            state_o.remaining = seg_len - MIN_SEG_LEN;
            if (is_sof) state_o.sof_off = 3'd0;
          end
        end
        PH_SKIP:   state_o.remaining = rem_dec;
        PH_SOF: begin
          state_o.height = height_new;
          state_o.width  = width_new;
          if (!zero_fail) begin
            state_o.remaining = rem_dec;
            if (state_i.sof_off < SOF_OFF_MAX) state_o.sof_off = state_i.sof_off + 3'd1;
          end
        end
        default: ;
      endcase
      state_o.decided = fail | ok;
    end

    result_o.vld          = fail | ok | (last_i & ~state_i.decided);
    result_o.size_found   = ok;
    result_o.image_width  = ok ? width_new  : 16'd0;
    result_o.image_height = ok ? height_new : 16'd0;
  end

endmodule

// ===== hdl/jpeg_frame_size_sniffer.sv =====
`timescale 1ns / 1ps
// a byte accepted into the input register gives its result, if any, from the result register
// (held back while an earlier result still waits in the result register)
// throughput: one byte per cycle unless output stalls; input register refills as result drains
// the parse step is one combinational pass between the input register and the result register
// reset (rst_n low, synchronous) clears the parse state, the input valid and the result valid
// ----------------------------------------------------------------------------
// jpeg_frame_size_sniffer
// Scans each JPEG frame for its first SOF segment; reports its size or a failure.
// ----------------------------------------------------------------------------
module jpeg_frame_size_sniffer (
  input  logic       clk,
  input  logic       rst_n,
  jfs_in_if.sink     in_stream,
  jfs_out_if.source  out_result
);
  import jfs_pkg::*;

  logic        in_valid_r;
  logic [7:0]  in_byte_r;
  logic        in_end_r;
  jfs_state_t  state_r;
  jfs_state_t  state_nxt;
  jfs_result_t res;
  logic        out_valid_r;
  logic        out_found_r;
  logic [15:0] out_width_r;
  logic [15:0] out_height_r;
  logic        advance;
  logic        out_free;

  assign out_free        = ~out_valid_r | out_result.ready;
  assign advance         = in_valid_r & out_free;
  assign in_stream.ready = ~in_valid_r | advance;

  jfs_parser u_parser (
    .state_i  (state_r),
    .byte_i   (in_byte_r),
    .last_i   (in_end_r),
    .state_o  (state_nxt),
    .result_o (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_stream.ready) begin
      in_valid_r <= in_stream.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_stream.ready && in_stream.valid) begin
      in_byte_r <= in_stream.stream_byte;
      in_end_r  <= in_stream.frame_end;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= '0;
    end else if (advance) begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= advance & res.vld;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && res.vld) begin
      out_found_r  <= res.size_found;
      out_width_r  <= res.image_width;
      out_height_r <= res.image_height;
    end
  end

  assign out_result.valid        = out_valid_r;
  assign out_result.size_found   = out_found_r;
  assign out_result.image_width  = out_width_r;
  assign out_result.image_height = out_height_r;

  // a failure never carries a size
  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_found_r |-> out_width_r == 16'd0 && out_height_r == 16'd0)
    else $error("failure result carries a nonzero size");

  // once decided, no second result before the frame end
  a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
    advance && state_r.decided && !in_end_r |-> !res.vld)
    else $error("second result within one frame");

  // a result mid-frame locks the parser
  a_lock: assert property (@(posedge clk) disable iff (!rst_n)
    advance && res.vld && !in_end_r |=> state_r.decided)
    else $error("parser not locked after a result");

  // the last byte rearms the parser
  a_rearm: assert property (@(posedge clk) disable iff (!rst_n)
    advance && in_end_r |=> !state_r.decided && state_r.phase == PH_START0)
    else $error("parser not rearmed after frame end");

endmodule
